### hdl/ppa_pkg.sv
// Package for the progressive pixel accumulator.
// Holds the item kind codes, the register map and the controller's state type.
// No dependencies.
`default_nettype none
package ppa_pkg;
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_EOF    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;
  localparam logic [8:0] DIM_RESET  = 9'd256;
  localparam int unsigned COUNT_BITS = 16;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MATH,
    ST_WAIT,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

### hdl/ppa_if.sv
// Valid/ready stream interfaces for input and result items.
// Depends on nothing.
`default_nettype none
interface ppa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  pix_x;
  logic [7:0]  pix_y;
  logic [15:0] sample_red;
  logic [15:0] sample_green;
  logic [15:0] sample_blue;
  modport source (output valid, kind, pix_x, pix_y, sample_red, sample_green,
                  sample_blue, input ready);
  modport sink (input valid, kind, pix_x, pix_y, sample_red, sample_green,
                sample_blue, output ready);
endinterface

interface ppa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_x;
  logic [7:0] out_y;
  logic       range_error;
  modport source (output valid, out_red, out_green, out_blue, out_x, out_y,
                  range_error, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_x, out_y,
                range_error, output ready);
endinterface
`default_nettype wire

### hdl/ppa_math.sv
// Per-channel byte unit: floor(4*acc/n) by restoring division, then an
// integer square root one result bit a cycle, shared across three channels.
// Depends on ppa_pkg.
`default_nettype none
module ppa_math #(
  parameter int ACC_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [3*ACC_BITS-1:0]        acc_in,
  input  wire logic [ppa_pkg::COUNT_BITS:0] n_in,
  output logic                              busy,
  output logic                              done,
  output logic [23:0]                       bytes
);
  localparam int QB = ACC_BITS + 2 + ACC_BITS % 2;
  localparam int RB = ppa_pkg::COUNT_BITS + 2;
  localparam int SB = QB / 2 + 1;
  localparam int CB = $clog2(QB + 1);

  logic [1:0]   chan;
  logic         phase;
  logic [CB-1:0] cnt;
  logic [QB-1:0] q;
  logic [RB-1:0] rem;
  logic [QB+1:0] srem;
  logic [SB-1:0] root;
  logic [QB-1:0] sq;
  logic [3*ACC_BITS-1:0] accs;
  logic [ppa_pkg::COUNT_BITS:0] n;

  logic [RB-1:0] rem_sh;
  logic [QB+1:0] srem_sh;
  logic [QB+1:0] trial;

  always_comb begin
    rem_sh  = {rem[RB-2:0], q[QB-1]};
    srem_sh = {srem[QB-1:0], sq[QB-1:QB-2]};
    trial   = {{(QB+2-SB-2){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        accs  <= acc_in;
        n     <= n_in;
        chan  <= 2'd0;
        phase <= 1'b0;
        cnt   <= CB'(QB);
        q     <= QB'({acc_in[ACC_BITS-1:0], 2'b00});
        rem   <= '0;
      end else if (busy) begin
        if (!phase) begin
          // Restoring division, one quotient bit a cycle.
          if (rem_sh >= RB'(n)) begin
            rem <= rem_sh - RB'(n);
            q   <= {q[QB-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[QB-2:0], 1'b0};
          end
          if (cnt == CB'(1)) begin
            phase <= 1'b1;
            cnt   <= CB'(SB);
            srem  <= '0;
            root  <= '0;
          end else begin
            cnt <= cnt - CB'(1);
          end
        end else begin
          if (cnt == CB'(SB)) begin
            // The final quotient sits in q, whose width QB is padded to an even number of bits for pairing.
            sq <= q;
          end
          if (cnt != CB'(SB)) begin
            sq <= {sq[QB-3:0], 2'b00};
            if (srem_sh >= trial) begin
              srem <= srem_sh - trial;
              root <= {root[SB-2:0], 1'b1};
            end else begin
              srem <= srem_sh;
              root <= {root[SB-2:0], 1'b0};
            end
          end
          if (cnt == CB'(0)) begin
            bytes <= {(root > SB'(255)) ? 8'd255 : root[7:0], bytes[23:8]};
            if (chan == 2'd2) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              chan  <= chan + 2'd1;
              accs  <= {{ACC_BITS{1'b0}}, accs[3*ACC_BITS-1:ACC_BITS]};
              phase <= 1'b0;
              cnt   <= CB'(QB);
              q     <= QB'({accs[2*ACC_BITS-1:ACC_BITS], 2'b00});
              rem   <= '0;
            end
          end else begin
            cnt <= cnt - CB'(1);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### hdl/progressive_pixel_accumulator.sv
// Progressive pixel accumulator: three channel accumulators per pixel in one
// memory, average over frames and gamma-2 byte conversion.
// Depends on ppa_pkg, ppa_if and ppa_math.
//
// Usage: sample items (kind 0) on in_ch each give one result on out_ch;
// end-of-frame (kind 1) bumps the frame count, clear (kind 2) zeroes the
// store and the count. Kind 3 is ignored. Items are taken one at a time.
// A sample in range passes through a memory read, a read-modify-write and the
// shared divide and square-root unit before its result is registered, and the
// next item can be taken once the block is back in idle. An out-of-range
// sample has its result in the cycle after acceptance.
// After reset and after each clear item a pass writes zero to all MAX_PIXELS
// entries, one a cycle, while no item is accepted; configuration writes are
// taken throughout. While a result waits in the output register for a stalled
// receiver, no new item is accepted.
// Registers: frame_width at 0x0, frame_height at 0x4, both reset to 256.
`default_nettype none
module progressive_pixel_accumulator #(
  parameter int MAX_PIXELS = 65536,
  parameter int ACC_BITS   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ppa_in_if.sink           in_ch,
  ppa_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int AB = $clog2(MAX_PIXELS);
  localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

  ppa_pkg::state_t state, state_next;
  logic [8:0] frame_width, frame_height;
  logic [15:0] frame_count;
  logic [AB:0] clr_addr;

  logic [3*ACC_BITS-1:0] mem [MAX_PIXELS];
  logic [3*ACC_BITS-1:0] rd_data;
  logic [AB-1:0] addr;
  logic [15:0] samp_r, samp_g, samp_b;
  logic [7:0] hold_x, hold_y;
  logic [3*ACC_BITS-1:0] sum;
  logic math_start, math_busy, math_done;
  logic [23:0] bytes;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= ppa_pkg::DIM_RESET;
      frame_height <= ppa_pkg::DIM_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ppa_pkg::REG_WIDTH) frame_width <= pwdata[8:0];
      else frame_height <= pwdata[8:0];
    end
  end
  always_comb begin
    prdata = {23'd0, (paddr[2] == ppa_pkg::REG_WIDTH) ? frame_width : frame_height};
  end

  // Address and range check.
  logic [17:0] full_addr;
  logic        bad;
  always_comb begin
    full_addr = {10'd0, in_ch.pix_y} * {9'd0, frame_width} + {10'd0, in_ch.pix_x};
    bad = ({1'b0, in_ch.pix_x} >= frame_width) || ({1'b0, in_ch.pix_y} >= frame_height)
          || (32'(full_addr) >= 32'(MAX_PIXELS));
  end

  logic in_fire, out_free;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ppa_pkg::ST_CLEAR: if (clr_addr == (AB+1)'(MAX_PIXELS - 1)) state_next = ppa_pkg::ST_IDLE;
      ppa_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == ppa_pkg::KIND_CLEAR) state_next = ppa_pkg::ST_CLEAR;
          else if (in_ch.kind == ppa_pkg::KIND_SAMPLE && !bad) state_next = ppa_pkg::ST_READ;
        end
      end
      ppa_pkg::ST_READ: state_next = ppa_pkg::ST_MATH;
      ppa_pkg::ST_MATH: state_next = ppa_pkg::ST_WAIT;
      ppa_pkg::ST_WAIT: if (math_done) state_next = ppa_pkg::ST_OUT;
      ppa_pkg::ST_OUT:  if (out_free) state_next = ppa_pkg::ST_IDLE;
      default: state_next = ppa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == ppa_pkg::ST_IDLE) && out_free;
    math_start  = (state == ppa_pkg::ST_MATH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ppa_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ppa_pkg::ST_CLEAR) clr_addr <= clr_addr + (AB+1)'(1);
      else clr_addr <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) frame_count <= '0;
    else if (in_fire && in_ch.kind == ppa_pkg::KIND_CLEAR) frame_count <= '0;
    else if (in_fire && in_ch.kind == ppa_pkg::KIND_EOF && frame_count != ppa_pkg::COUNT_MAX)
      frame_count <= frame_count + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr   <= AB'(full_addr);
      samp_r <= in_ch.sample_red;
      samp_g <= in_ch.sample_green;
      samp_b <= in_ch.sample_blue;
      hold_x <= in_ch.pix_x;
      hold_y <= in_ch.pix_y;
    end
  end

  // Saturating add of each channel.
  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                  input logic [15:0] s);
    logic [ACC_BITS:0] t;
    t = {1'b0, a} + (ACC_BITS+1)'(s);
    return t[ACC_BITS] ? ACC_MAX : t[ACC_BITS-1:0];
  endfunction

  always_comb begin
    sum = {sat_add(rd_data[3*ACC_BITS-1:2*ACC_BITS], samp_b),
           sat_add(rd_data[2*ACC_BITS-1:ACC_BITS], samp_g),
           sat_add(rd_data[ACC_BITS-1:0], samp_r)};
  end

  // Synchronous memory: one read, one write per cycle.
  always_ff @(posedge clk) begin
    if (state == ppa_pkg::ST_CLEAR) mem[clr_addr[AB-1:0]] <= '0;
    else if (state == ppa_pkg::ST_MATH) mem[addr] <= sum;
    rd_data <= mem[addr];
  end

  ppa_math #(.ACC_BITS(ACC_BITS)) u_math (
    .clk(clk), .rst(rst), .start(math_start), .acc_in(sum),
    .n_in({1'b0, frame_count} + 17'd1), .busy(math_busy), .done(math_done),
    .bytes(bytes)
  );

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (in_fire && in_ch.kind == ppa_pkg::KIND_SAMPLE && bad) out_ch.valid <= 1'b1;
    else if (state == ppa_pkg::ST_OUT && out_free) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == ppa_pkg::KIND_SAMPLE && bad) begin
      out_ch.out_red <= '0; out_ch.out_green <= '0; out_ch.out_blue <= '0;
      out_ch.out_x <= in_ch.pix_x; out_ch.out_y <= in_ch.pix_y;
      out_ch.range_error <= 1'b1;
    end else if (state == ppa_pkg::ST_OUT && out_free) begin
      out_ch.out_red <= bytes[7:0]; out_ch.out_green <= bytes[15:8];
      out_ch.out_blue <= bytes[23:16];
      out_ch.out_x <= hold_x; out_ch.out_y <= hold_y;
      out_ch.range_error <= 1'b0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ppa_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_math_idle_start: assert property (@(posedge clk) disable iff (rst)
    math_start |-> !math_busy) else $error("math started while busy");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    math_done |-> (state == ppa_pkg::ST_WAIT)) else $error("stray done");
endmodule
`default_nettype wire

### tb/ppa_tb_types.sv
// Item and result records shared by the stimulus, driver and checker.
// Depends on ppa_pkg for the item kind codes.
package ppa_tb_types;
  typedef struct {
    ppa_pkg::kind_t kind;
    logic [7:0]     pix_x;
    logic [7:0]     pix_y;
    logic [15:0]    red;
    logic [15:0]    green;
    logic [15:0]    blue;
  } pixel_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pix_x;
    logic [7:0] pix_y;
    logic       range_error;
  } pixel_result_t;
endpackage

### tb/testbench.sv
// Self-checking bench for progressive_pixel_accumulator: predicts each pixel
// result from its own model of the accumulator store and frame count.
// Depends on ppa_pkg, ppa_if, ppa_tb_types and the block itself.
module testbench;
  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ppa_in_if  in_ch ();
  ppa_out_if out_ch ();

  progressive_pixel_accumulator dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int unsigned STORE_DEPTH = 65536;
  localparam longint unsigned ACC_LIMIT = 64'hFFFF_FFFF;

  ppa_tb_types::pixel_item_t   item_q[$];
  ppa_tb_types::pixel_result_t pixel_expect_q[$];
  logic [95:0]   acc_model[int];
  logic [15:0]   frames_done;
  logic [8:0]    dim_w;
  logic [8:0]    dim_h;
  logic          in_took;
  logic          steady;
  int            gap_left;
  int            burst_left;
  int            ready_pct;
  int            stall_cycle;
  int            fails;
  int            n_samples, n_rejects, n_frames, n_clears, n_ignored;
  logic [7:0]    hot_x[16];
  logic [7:0]    hot_y[16];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("progressive_pixel_accumulator: mismatch");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bit_w;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  function automatic logic [7:0] gamma_byte(longint unsigned acc, longint unsigned n);
    longint unsigned r;
    r = floor_sqrt((acc * 4) / n);
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // Applies one accepted item to the model and queues its result, if any.
  task automatic accumulate_item(ppa_tb_types::pixel_item_t it);
    longint unsigned addr;
    longint unsigned acc;
    longint unsigned smp;
    longint unsigned n;
    logic [95:0]     entry;
    ppa_tb_types::pixel_result_t res;
    case (it.kind)
      ppa_pkg::KIND_EOF: begin
        if (frames_done != ppa_pkg::COUNT_MAX) frames_done = frames_done + 16'd1;
        n_frames++;
      end
      ppa_pkg::KIND_CLEAR: begin
        acc_model.delete();
        frames_done = '0;
        n_clears++;
      end
      ppa_pkg::KIND_SAMPLE: begin
        addr = 64'(it.pix_y) * 64'(dim_w) + 64'(it.pix_x);
        res.pix_x = it.pix_x;
        res.pix_y = it.pix_y;
        if (it.pix_x >= dim_w || it.pix_y >= dim_h || addr >= STORE_DEPTH) begin
          res.red = '0;
          res.green = '0;
          res.blue = '0;
          res.range_error = 1'b1;
          n_rejects++;
        end else begin
          entry = acc_model.exists(int'(addr)) ? acc_model[int'(addr)] : '0;
          for (int c = 0; c < 3; c++) begin
            acc = 64'(entry[c*32 +: 32]);
            smp = (c == 0) ? 64'(it.red) : (c == 1) ? 64'(it.green) : 64'(it.blue);
            acc = (ACC_LIMIT - acc < smp) ? ACC_LIMIT : acc + smp;
            entry[c*32 +: 32] = acc[31:0];
          end
          acc_model[int'(addr)] = entry;
          n = 64'(frames_done) + 64'd1;
          res.red   = gamma_byte(64'(entry[31:0]), n);
          res.green = gamma_byte(64'(entry[63:32]), n);
          res.blue  = gamma_byte(64'(entry[95:64]), n);
          res.range_error = 1'b0;
          n_samples++;
        end
        pixel_expect_q.push_back(res);
      end
      default: n_ignored++;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    ppa_tb_types::pixel_item_t   it;
    ppa_tb_types::pixel_result_t want;
    in_took <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      it.kind  = ppa_pkg::kind_t'(in_ch.kind);
      it.pix_x = in_ch.pix_x;
      it.pix_y = in_ch.pix_y;
      it.red   = in_ch.sample_red;
      it.green = in_ch.sample_green;
      it.blue  = in_ch.sample_blue;
      accumulate_item(it);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pixel_expect_q.size() == 0) begin
        $error("unexpected result for pixel (%0d,%0d)", out_ch.out_x, out_ch.out_y);
        fails++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_ch.out_red !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, out_ch.out_red);
          fails++;
        end
        if (out_ch.out_green !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, out_ch.out_green);
          fails++;
        end
        if (out_ch.out_blue !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, out_ch.out_blue);
          fails++;
        end
        if (out_ch.out_x !== want.pix_x) begin
          $error("out_x: expected %0d, actual %0d", want.pix_x, out_ch.out_x);
          fails++;
        end
        if (out_ch.out_y !== want.pix_y) begin
          $error("out_y: expected %0d, actual %0d", want.pix_y, out_ch.out_y);
          fails++;
        end
        if (out_ch.range_error !== want.range_error) begin
          $error("range_error: expected %0d, actual %0d", want.range_error,
                 out_ch.range_error);
          fails++;
        end
      end
    end
  end

  // Sender: bursts of transactions separated by random gaps, unless steady.
  always @(negedge clk) begin : driver
    ppa_tb_types::pixel_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (gap_left > 0 && !steady) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (item_q.size() > 0) begin
        it = item_q.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= it.kind;
        in_ch.pix_x        <= it.pix_x;
        in_ch.pix_y        <= it.pix_y;
        in_ch.sample_red   <= it.red;
        in_ch.sample_green <= it.green;
        in_ch.sample_blue  <= it.blue;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: the acceptance probability is drawn anew each time stall_cycle wraps.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_cycle == 255) begin
        case ($urandom_range(0, 3))
          0: ready_pct <= 100;
          1: ready_pct <= 70;
          2: ready_pct <= 30;
          default: ready_pct <= 5;
        endcase
      end
      stall_cycle <= (stall_cycle + 1) % 256;
      out_ch.ready <= steady || ($urandom_range(0, 99) < ready_pct);
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == ppa_pkg::REG_WIDTH) dim_w = value[8:0];
    else dim_h = value[8:0];
  endtask

  task automatic set_dims(int w, int h);
    write_reg(ppa_pkg::REG_WIDTH, 32'(w));
    write_reg(ppa_pkg::REG_HEIGHT, 32'(h));
  endtask

  task automatic push_item(ppa_pkg::kind_t k, int x, int y, int r, int g, int b);
    ppa_tb_types::pixel_item_t it;
    it.kind  = k;
    it.pix_x = 8'(x);
    it.pix_y = 8'(y);
    it.red   = 16'(r);
    it.green = 16'(g);
    it.blue  = 16'(b);
    item_q.push_back(it);
  endtask

  // Waits until every transaction has been taken and answered, then lets the
  // block finish an end-of-frame or ignored item; a clear pass may still be running.
  task automatic drain();
    do @(posedge clk);
    while (item_q.size() != 0 || in_ch.valid || pixel_expect_q.size() != 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 4))
      0: return 16'hFFFF;
      1: return $urandom_range(0, 255);
      2: return 0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic push_random(int count);
    int sel, x, y, xmax, ymax, h;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      xmax = (dim_w > 256) ? 255 : int'(dim_w) - 1;
      ymax = (dim_h > 256) ? 255 : int'(dim_h) - 1;
      if (sel < 8) begin
        push_item(ppa_pkg::KIND_EOF, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
      end else if (sel < 11) begin
        push_item(ppa_pkg::KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                  rand_sample(), rand_sample(), rand_sample());
      end else if (sel < 18 || xmax < 0 || ymax < 0) begin
        push_item(ppa_pkg::KIND_SAMPLE, $urandom_range(0, 255), $urandom_range(0, 255),
                  rand_sample(), rand_sample(), rand_sample());
      end else begin
        // Repeated hits on a few pixels build up the accumulators.
        if ($urandom_range(0, 9) < 6) begin
          h = $urandom_range(0, 15);
          x = int'(hot_x[h]) % (xmax + 1);
          y = int'(hot_y[h]) % (ymax + 1);
        end else begin
          x = $urandom_range(0, xmax);
          y = $urandom_range(0, ymax);
        end
        push_item(ppa_pkg::KIND_SAMPLE, x, y, rand_sample(), rand_sample(),
                  rand_sample());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = ppa_pkg::KIND_NONE;
    in_ch.pix_x = '0;
    in_ch.pix_y = '0;
    in_ch.sample_red = '0;
    in_ch.sample_green = '0;
    in_ch.sample_blue = '0;
    out_ch.ready = 1'b0;
    in_took = 1'b0;
    steady = 1'b0;
    gap_left = 0;
    burst_left = 0;
    ready_pct = 100;
    stall_cycle = 0;
    fails = 0;
    n_samples = 0;
    n_rejects = 0;
    n_frames = 0;
    n_clears = 0;
    n_ignored = 0;
    frames_done = '0;
    dim_w = ppa_pkg::DIM_RESET;
    dim_h = ppa_pkg::DIM_RESET;
    for (int i = 0; i < 16; i++) begin
      hot_x[i] = 8'($urandom_range(0, 255));
      hot_y[i] = 8'($urandom_range(0, 255));
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_dims(256, 256);
    push_item(ppa_pkg::KIND_SAMPLE, 0, 0, 0, 0, 0);
    push_item(ppa_pkg::KIND_SAMPLE, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(ppa_pkg::KIND_SAMPLE, 255, 0, 16'h5555, 16'hAAAA, 16'h0001);
    push_item(ppa_pkg::KIND_SAMPLE, 255, 255, 16'hFFFF, 16'h0000, 16'h8000);
    push_item(ppa_pkg::KIND_NONE, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(ppa_pkg::KIND_EOF, 0, 0, 0, 0, 0);
    push_item(ppa_pkg::KIND_SAMPLE, 255, 255, 16'h4000, 16'h4000, 16'h4000);
    push_item(ppa_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
    push_item(ppa_pkg::KIND_SAMPLE, 255, 255, 16'h4000, 16'hFFFF, 16'h0000);
    drain();

    // A run of frame ends without gaps, then samples at the raised count.
    steady = 1'b1;
    for (int i = 0; i < 40; i++) push_item(ppa_pkg::KIND_EOF, 0, 0, 0, 0, 0);
    push_item(ppa_pkg::KIND_SAMPLE, 7, 9, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(ppa_pkg::KIND_SAMPLE, 7, 9, 16'hFFFF, 16'h0100, 16'h0000);
    drain();
    push_random(150);
    drain();
    steady = 1'b0;
    push_random(250);
    drain();

    push_item(ppa_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
    push_random(250);
    drain();

    set_dims(1, 1);
    push_item(ppa_pkg::KIND_SAMPLE, 0, 0, 16'hFFFF, 16'h1234, 16'h0000);
    push_item(ppa_pkg::KIND_SAMPLE, 1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(ppa_pkg::KIND_SAMPLE, 0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(80);
    drain();

    // A width above 256 lets the address run past the store.
    set_dims(300, 256);
    push_item(ppa_pkg::KIND_SAMPLE, 255, 218, 16'h2000, 16'h3000, 16'h4000);
    push_item(ppa_pkg::KIND_SAMPLE, 0, 219, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(ppa_pkg::KIND_SAMPLE, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(250);
    drain();

    set_dims(17, 9);
    push_item(ppa_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
    push_random(250);
    drain();

    set_dims(0, 5);
    push_item(ppa_pkg::KIND_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(30);
    drain();

    set_dims(256, 0);
    push_item(ppa_pkg::KIND_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(30);
    drain();

    set_dims(511, 511);
    push_random(40);
    drain();

    set_dims(256, 256);
    push_random(200);
    drain();

    $display("covered %0d accumulated samples, %0d rejected pixels, %0d frame ends,",
             n_samples, n_rejects, n_frames);
    $display("%0d clears and %0d unused kinds over eight size settings",
             n_clears, n_ignored);
    if (fails == 0 && pixel_expect_q.size() == 0) begin
      $display("progressive_pixel_accumulator: match");
    end else begin
      $display("progressive_pixel_accumulator: mismatch");
    end
    $finish;
  end
endmodule

### files.f
hdl/ppa_pkg.sv
hdl/ppa_if.sv
hdl/ppa_math.sv
hdl/progressive_pixel_accumulator.sv
tb/ppa_tb_types.sv
tb/testbench.sv
